FILE: rtl/core/g2g_pkg.sv
// shared types, constants and tables for the go-to-goal controller
// depends on nothing
`timescale 1ns / 1ps
package g2g_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;
  localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES :
                        ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);

  localparam logic signed [19:0] PI_Q16       = 20'sd205887;
  localparam logic signed [17:0] PI_Q13       = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13   = 18'sd51472;
  localparam logic signed [17:0] HALF_PI_Q13  = 18'sd12868;
  localparam logic        [15:0] INV_GAIN_Q16 = 16'd39797;

  localparam logic [2:0] REG_GOAL_X   = 3'd0;
  localparam logic [2:0] REG_GOAL_Y   = 3'd1;
  localparam logic [2:0] REG_LIN_GAIN = 3'd2;
  localparam logic [2:0] REG_ANG_GAIN = 3'd3;
  localparam logic [2:0] REG_LIN_UP   = 3'd4;
  localparam logic [2:0] REG_LIN_LO   = 3'd5;
  localparam logic [2:0] REG_ANG_LIM  = 3'd6;
  localparam logic [2:0] REG_ARRIVE   = 3'd7;

  // one word travelling down the cell row
  typedef struct packed {
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [21:0] z;
    logic signed [15:0] head;
  } vec_t;

  // atan(2^-i) in Q16 radians
  function automatic logic signed [21:0] atan_q16(input int i);
    case (i)
      0: atan_q16 = 22'sd51472;  1: atan_q16 = 22'sd30386;
      2: atan_q16 = 22'sd16055;  3: atan_q16 = 22'sd8150;
      4: atan_q16 = 22'sd4091;   5: atan_q16 = 22'sd2047;
      6: atan_q16 = 22'sd1024;   7: atan_q16 = 22'sd512;
      8: atan_q16 = 22'sd256;    9: atan_q16 = 22'sd128;
      10: atan_q16 = 22'sd64;    11: atan_q16 = 22'sd32;
      12: atan_q16 = 22'sd16;    13: atan_q16 = 22'sd8;
      14: atan_q16 = 22'sd4;     15: atan_q16 = 22'sd2;
      16: atan_q16 = 22'sd1;
      default: atan_q16 = 22'sd0;
    endcase
  endfunction

endpackage

FILE: rtl/core/g2g_cell.sv
// one cordic micro-rotation cell, vectoring or rotation mode
// depends on g2g_pkg
`timescale 1ns / 1ps
module g2g_cell import g2g_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] shift,
  input  logic       rot_mode,
  input  vec_t       d_in,
  output vec_t       d_out_r
);
  vec_t d_nxt;
  logic signed [27:0] xs, ys;
  logic signed [21:0] a;
  logic up;

  // arithmetic shifts floor
  always_comb begin
    xs = d_in.x >>> shift;
    ys = d_in.y >>> shift;
    a  = atan_q16(int'(shift));
    up = rot_mode ? (d_in.z >= 0) : (d_in.y >= 0);
    d_nxt = d_in;
    if (up == !rot_mode) begin
      d_nxt.x = d_in.x + ys; d_nxt.y = d_in.y - xs; d_nxt.z = d_in.z + a;
    end else begin
      d_nxt.x = d_in.x - ys; d_nxt.y = d_in.y + xs; d_nxt.z = d_in.z - a;
    end
    if (rot_mode && up) begin
      d_nxt.x = d_in.x - ys; d_nxt.y = d_in.y + xs; d_nxt.z = d_in.z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out_r <= d_nxt;
  end
endmodule

FILE: rtl/core/g2g_row.sv
// row of cordic cells with a valid bit per stage
// depends on g2g_pkg, g2g_cell
`timescale 1ns / 1ps
module g2g_row import g2g_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic rot_mode,
  input  logic v_in,
  input  vec_t d_in,
  output logic v_out,
  output vec_t d_out
);
  vec_t chain [NSTG+1];
  logic [NSTG:0] vld_r;

  assign chain[0] = d_in;

  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    g2g_cell u_cell (
      .clk(clk), .en(en), .shift(5'(g)), .rot_mode(rot_mode),
      .d_in(chain[g]), .d_out_r(chain[g+1])
    );
  end

  // valid bits shift with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[NSTG:1] <= '0;
    else if (en) vld_r[NSTG:1] <= vld_r[NSTG-1:0];
  end
  assign vld_r[0] = v_in;

  assign v_out = vld_r[NSTG];
  assign d_out = chain[NSTG];
endmodule

FILE: rtl/core/go_to_goal_p_controller.sv
// Go-to-goal proportional controller. One pose word per cycle in, one speed
// command word out, in order. The stages are a row of vectoring cordic cells
// for distance and bearing, then a row of rotation cells for the cosine
// gate, then scaling and clamping stages. The whole pipeline advances
// together and freezes while the output is stalled.
// depends on g2g_pkg, g2g_row
`timescale 1ns / 1ps
module go_to_goal_p_controller import g2g_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_pose_x,
  input  logic signed [15:0] in_pose_y,
  input  logic signed [15:0] in_pose_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_linear_speed,
  output logic signed [15:0] out_angular_speed,
  output logic               out_at_goal
);
  logic signed [15:0] goal_x_r, goal_y_r, lin_up_r, lin_lo_r;
  logic [15:0] lin_gain_r, ang_gain_r;
  logic [14:0] ang_lim_r, arrive_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= 16'sd9216; goal_y_r <= 16'sd2048;
      lin_gain_r <= 16'd7373; ang_gain_r <= 16'd16384;
      lin_up_r <= 16'sd2048; lin_lo_r <= 16'sd51;
      ang_lim_r <= 15'd3072; arrive_r <= 15'd51;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:   goal_x_r <= cfg_data;
        REG_GOAL_Y:   goal_y_r <= cfg_data;
        REG_LIN_GAIN: lin_gain_r <= cfg_data;
        REG_ANG_GAIN: ang_gain_r <= cfg_data;
        REG_LIN_UP:   lin_up_r <= cfg_data;
        REG_LIN_LO:   lin_lo_r <= cfg_data;
        REG_ANG_LIM:  ang_lim_r <= cfg_data[14:0];
        REG_ARRIVE:   arrive_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished word is held
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 0: offsets and quadrant fold
  logic v0_r;
  vec_t d0_r, d0_nxt;
  logic signed [16:0] dx, dy;
  always_comb begin
    dx = 17'(goal_x_r) - 17'(in_pose_x);
    dy = 17'(goal_y_r) - 17'(in_pose_y);
    d0_nxt.head = in_pose_heading;
    d0_nxt.x = 28'(dx) <<< 8;
    d0_nxt.y = 28'(dy) <<< 8;
    d0_nxt.z = '0;
    if (dx < 0) begin
      d0_nxt.x = -(28'(dx) <<< 8);
      d0_nxt.y = -(28'(dy) <<< 8);
      d0_nxt.z = (dy >= 0) ? 22'(PI_Q16) : -22'(PI_Q16);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
    if (en) d0_r <= d0_nxt;
  end

  logic v1; vec_t d1;
  g2g_row u_vec (.clk(clk), .rst_n(rst_n), .en(en), .rot_mode(1'b0),
    .v_in(v0_r), .d_in(d0_r), .v_out(v1), .d_out(d1));

  // stage a: gain product for distance, bearing rounding
  logic va_r;
  logic signed [44:0] dprod_r;
  logic signed [17:0] bear_a_r;
  logic signed [15:0] head_a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= v1;
    if (en) begin
      dprod_r <= 45'(d1.x) * 45'($signed({1'b0, INV_GAIN_Q16}));
      bear_a_r <= 18'((d1.z + 22'sd4) >>> 3);
      head_a_r <= d1.head;
    end
  end

  // stage b: distance, wrapped error, cos row setup
  logic vb_r, gate0_b;
  logic signed [20:0] dist_nxt;
  logic signed [17:0] err_nxt, aerr;
  vec_t db_nxt;
  always_comb begin
    dist_nxt = 21'((dprod_r + 45'sd8388608) >>> 24);
    err_nxt = bear_a_r - 18'(head_a_r);
    if (err_nxt > PI_Q13) err_nxt = err_nxt - TWO_PI_Q13;
    else if (err_nxt < -PI_Q13) err_nxt = err_nxt + TWO_PI_Q13;
    aerr = err_nxt < 0 ? -err_nxt : err_nxt;
    db_nxt.x = 28'(INV_GAIN_Q16) <<< 8;
    db_nxt.y = '0;
    db_nxt.z = 22'(aerr) <<< 3;
    db_nxt.head = '0;
    gate0_b = aerr >= HALF_PI_Q13;
  end

  vec_t db_r;
  logic gz_r [NSTG+1];
  logic signed [20:0] dist_p [NSTG+1];
  logic signed [17:0] err_p [NSTG+1];
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (en) vb_r <= va_r;
    if (en) begin
      db_r <= db_nxt;
      gz_r[0] <= gate0_b; dist_p[0] <= dist_nxt; err_p[0] <= err_nxt;
    end
  end

  // side delay line matching the cosine row
  for (genvar g = 0; g < NSTG; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        gz_r[g+1] <= gz_r[g]; dist_p[g+1] <= dist_p[g]; err_p[g+1] <= err_p[g];
      end
    end
  end

  logic v2; vec_t d2;
  g2g_row u_cos (.clk(clk), .rst_n(rst_n), .en(en), .rot_mode(1'b1),
    .v_in(vb_r), .d_in(db_r), .v_out(v2), .d_out(d2));

  // stage c: cosine gate, arrival test, angular product, distance times gain
  logic vc_r, goal_c_r;
  logic [15:0] cos_c_r;
  logic signed [34:0] wprod_r;
  logic [32:0] lg_r;
  logic signed [27:0] craw;
  logic [15:0] cg;
  logic signed [20:0] dist_c;
  always_comb begin
    craw = (d2.x + 28'sd256) >>> 9;
    if (craw < 0) cg = '0;
    else if (craw > 28'sd32768) cg = 16'd32768;
    else cg = craw[15:0];
    if (gz_r[NSTG]) cg = '0;
    dist_c = dist_p[NSTG];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= v2;
    if (en) begin
      cos_c_r <= cg;
      goal_c_r <= dist_c <= $signed({6'd0, arrive_r});
      wprod_r <= 35'(err_p[NSTG]) * $signed({1'b0, ang_gain_r});
      lg_r <= 33'(dist_c[16:0]) * 33'(lin_gain_r);
    end
  end

  // stage d: linear product, angular clamp
  logic vd_r, goal_d_r;
  logic [47:0] lprod_r;
  logic signed [15:0] w_d_r;
  logic signed [19:0] w_full, lim;
  always_comb begin
    w_full = 20'((wprod_r + 35'sd16384) >>> 15);
    lim = $signed({5'd0, ang_lim_r});
    if (w_full > lim) w_full = lim;
    if (w_full < -lim) w_full = -lim;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (en) vd_r <= vc_r;
    if (en) begin
      lprod_r <= 48'(lg_r) * 48'(cos_c_r);
      w_d_r <= w_full[15:0];
      goal_d_r <= goal_c_r;
    end
  end

  // stage e: linear clamp and output word
  logic [20:0] raw;
  logic signed [21:0] v;
  always_comb begin
    raw = 21'((lprod_r + 48'd67108864) >> 27);
    if (raw > 21'h10000) raw = 21'h10000;
    v = $signed({1'b0, raw});
    if (v < 22'(lin_lo_r)) v = 22'(lin_lo_r);
    if (v > 22'(lin_up_r)) v = 22'(lin_up_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= vd_r;
    if (en) begin
      out_linear_speed  <= goal_d_r ? 16'sd0 : v[15:0];
      out_angular_speed <= goal_d_r ? 16'sd0 : w_d_r;
      out_at_goal       <= goal_d_r;
    end
  end
endmodule
